@@ rtl/positional_sequence_store_unit_macros.svh @@
// Assertion macros for the positional sequence store.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef POSITIONAL_SEQUENCE_STORE_UNIT_MACROS_SVH
`define POSITIONAL_SEQUENCE_STORE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pss_pkg.sv @@
// Shared types, codes and controller/datapath bundles for the sequence store.
// No dependencies.
package pss_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 3;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 7;
    localparam int AMT_W        = 31;
    localparam int ST_W         = 2;
    localparam int LEN_W        = 7;

    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_INSERT  = 3'd0;
    localparam t_op OP_REMOVE  = 3'd1;
    localparam t_op OP_DUMP    = 3'd2;
    localparam t_op OP_MOVE    = 3'd3;
    localparam t_op OP_REVERSE = 3'd4;
    localparam t_op OP_ROTL    = 3'd5;
    localparam t_op OP_ROTR    = 3'd6;

    typedef logic [ST_W-1:0] t_st;
    localparam t_st ST_OK    = 2'd0;
    localparam t_st ST_FULL  = 2'd1;
    localparam t_st ST_RANGE = 2'd2;

    // index register operations
    typedef logic [3:0] t_idx_op;
    localparam t_idx_op IDX_HOLD   = 4'd0;
    localparam t_idx_op IDX_UP     = 4'd1;  // i++, j++
    localparam t_idx_op IDX_DN     = 4'd2;  // i--, j--
    localparam t_idx_op IDX_CLOSE  = 4'd3;  // i++, j--
    localparam t_idx_op IDX_INS    = 4'd4;  // i = n, j = n-1
    localparam t_idx_op IDX_FWD    = 4'd5;  // i = pos, j = pos+1
    localparam t_idx_op IDX_BWD    = 4'd6;  // i = pos, j = pos-1
    localparam t_idx_op IDX_FLIP_A = 4'd7;  // i = 0, j = k-1
    localparam t_idx_op IDX_FLIP_B = 4'd8;  // i = k, j = n-1
    localparam t_idx_op IDX_ZERO   = 4'd9;  // i = 0, j = n-1

    typedef logic [1:0] t_wd;
    localparam t_wd WD_RDATA = 2'd0;
    localparam t_wd WD_VALUE = 2'd1;
    localparam t_wd WD_TMP   = 2'd2;

    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        logic    rd_j;
        logic    wr_en;
        logic    wr_j;
        t_wd     wd_sel;
        logic    tmp_ld;
        t_idx_op idx_op;
        logic    mod_start;
        logic    out_ld;
        logic    out_dump;
        t_st     st;
        logic    fill_inc;
        logic    fill_dec;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic pos_gt_n;
        logic pos_ge_n;
        logic tgt_ge_n;
        logic pos_eq_tgt;
        logic tgt_gt_pos;
        logic n_lt2;
        logic n_zero;
        logic i_gt_pos;
        logic j_lt_n;
        logic i_lt_tgt;
        logic i_gt_tgt;
        logic i_lt_j;
        logic i_last;
        logic k_zero;
        logic mod_done;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/pss_if.sv @@
// Valid/ready channel interfaces for the sequence store's item and result streams.
// Depends on pss_pkg.
interface pss_in_if;
    logic                              valid;
    logic                              ready;
    logic [pss_pkg::OP_W-1:0]          op;
    logic signed [pss_pkg::VAL_W-1:0]  value;
    logic [pss_pkg::POS_W-1:0]         position;
    logic [pss_pkg::POS_W-1:0]         target_position;
    logic [pss_pkg::AMT_W-1:0]         amount;

    modport source (output valid, op, value, position, target_position, amount,
                    input ready);
    modport sink   (input valid, op, value, position, target_position, amount,
                    output ready);
endinterface

interface pss_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [pss_pkg::VAL_W-1:0]  element;
    logic                              has_element;
    logic [pss_pkg::ST_W-1:0]          status;
    logic [pss_pkg::LEN_W-1:0]         length;
    logic                              last;

    modport source (output valid, element, has_element, status, length, last,
                    input ready);
    modport sink   (input valid, element, has_element, status, length, last,
                    output ready);
endinterface

@@ rtl/pss_mod.sv @@
// Bit-serial remainder unit: dividend % divisor, one quotient bit per cycle.
// Depends on pss_pkg.
module pss_mod #(
    parameter int CW = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pss_pkg::AMT_W-1:0]  i_dividend,
    input  logic [CW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [CW-1:0]              o_rem
);
    localparam int BW = $clog2(pss_pkg::AMT_W);

    logic                      r_busy;
    logic [BW-1:0]             r_cnt;
    logic [pss_pkg::AMT_W-1:0] r_q;
    logic [CW-1:0]             r_rem;
    logic [CW:0]               trial;
    logic [CW:0]               diff;
    logic [CW-1:0]             n_rem;

    always_comb begin
        trial = {r_rem, r_q[pss_pkg::AMT_W-1]};
        diff  = trial - {1'b0, i_divisor};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = diff[CW-1:0];
        end else begin
            n_rem = trial[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= BW'(pss_pkg::AMT_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[pss_pkg::AMT_W-2:0], 1'b0};
        end
    end

    assign o_done = !r_busy;
    assign o_rem  = r_rem;
endmodule

@@ rtl/pss_ctrl.sv @@
// Sequencer for the store: decodes each item and steps the datapath loops.
// Depends on pss_pkg.
module pss_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pss_pkg::t_stat  i_stat,
    output pss_pkg::t_cmd   o_cmd
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_MV_RD    = 4'd2;
    localparam logic [3:0] S_MV_TMP   = 4'd3;
    localparam logic [3:0] S_CP_RD    = 4'd4;
    localparam logic [3:0] S_CP_WR    = 4'd5;
    localparam logic [3:0] S_PUT      = 4'd6;
    localparam logic [3:0] S_MOD      = 4'd7;
    localparam logic [3:0] S_SW_RDI   = 4'd8;
    localparam logic [3:0] S_SW_RDJ   = 4'd9;
    localparam logic [3:0] S_SW_WRI   = 4'd10;
    localparam logic [3:0] S_SW_WRJ   = 4'd11;
    localparam logic [3:0] S_DUMP_RD  = 4'd12;
    localparam logic [3:0] S_DUMP_OUT = 4'd13;
    localparam logic [3:0] S_FIN      = 4'd14;

    localparam logic [1:0] K_INS  = 2'd0;
    localparam logic [1:0] K_REM  = 2'd1;
    localparam logic [1:0] K_MVUP = 2'd2;
    localparam logic [1:0] K_MVDN = 2'd3;

    localparam logic [1:0] PH_REV = 2'd0;
    localparam logic [1:0] PH_A   = 2'd1;
    localparam logic [1:0] PH_B   = 2'd2;
    localparam logic [1:0] PH_C   = 2'd3;

    logic [3:0]     r_state, n_state;
    logic [1:0]     r_kind, n_kind;
    logic [1:0]     r_phase, n_phase;
    pss_pkg::t_st   r_st, n_st;
    logic           cont;

    always_comb begin
        unique case (r_kind)
            K_INS:   cont = i_stat.i_gt_pos;
            K_REM:   cont = i_stat.j_lt_n;
            K_MVUP:  cont = i_stat.i_lt_tgt;
            default: cont = i_stat.i_gt_tgt;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_kind  = r_kind;
        n_phase = r_phase;
        n_st    = r_st;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_st            = pss_pkg::ST_OK;
                    n_state         = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_FIN;
                unique case (i_stat.op)
                    pss_pkg::OP_INSERT: begin
                        if (i_stat.full) begin
                            n_st = pss_pkg::ST_FULL;
                        end else if (i_stat.pos_gt_n) begin
                            n_st = pss_pkg::ST_RANGE;
                        end else begin
                            o_cmd.idx_op = pss_pkg::IDX_INS;
                            n_kind       = K_INS;
                            n_state      = S_CP_RD;
                        end
                    end
                    pss_pkg::OP_REMOVE: begin
                        if (i_stat.pos_ge_n) begin
                            n_st = pss_pkg::ST_RANGE;
                        end else begin
                            o_cmd.idx_op = pss_pkg::IDX_FWD;
                            n_kind       = K_REM;
                            n_state      = S_CP_RD;
                        end
                    end
                    pss_pkg::OP_DUMP: begin
                        if (!i_stat.n_zero) begin
                            o_cmd.idx_op = pss_pkg::IDX_ZERO;
                            n_state      = S_DUMP_RD;
                        end
                    end
                    pss_pkg::OP_MOVE: begin
                        if (i_stat.pos_ge_n || i_stat.tgt_ge_n) begin
                            n_st = pss_pkg::ST_RANGE;
                        end else if (!i_stat.pos_eq_tgt) begin
                            if (i_stat.tgt_gt_pos) begin
                                o_cmd.idx_op = pss_pkg::IDX_FWD;
                                n_kind       = K_MVUP;
                            end else begin
                                o_cmd.idx_op = pss_pkg::IDX_BWD;
                                n_kind       = K_MVDN;
                            end
                            n_state = S_MV_RD;
                        end
                    end
                    pss_pkg::OP_REVERSE: begin
                        if (!i_stat.n_lt2) begin
                            o_cmd.idx_op = pss_pkg::IDX_ZERO;
                            n_phase      = PH_REV;
                            n_state      = S_SW_RDI;
                        end
                    end
                    pss_pkg::OP_ROTL, pss_pkg::OP_ROTR: begin
                        if (!i_stat.n_lt2) begin
                            o_cmd.mod_start = 1'b1;
                            n_state         = S_MOD;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_MV_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_MV_TMP;
            end
            S_MV_TMP: begin
                o_cmd.tmp_ld = 1'b1;
                n_state      = S_CP_RD;
            end
            S_CP_RD: begin
                if (cont) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_j  = 1'b1;
                    n_state     = S_CP_WR;
                end else if (r_kind == K_REM) begin
                    o_cmd.fill_dec = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_CP_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wd_sel = pss_pkg::WD_RDATA;
                o_cmd.idx_op = (r_kind == K_INS || r_kind == K_MVDN) ?
                               pss_pkg::IDX_DN : pss_pkg::IDX_UP;
                n_state      = S_CP_RD;
            end
            S_PUT: begin
                // index has landed on the insert position or move target
                o_cmd.wr_en    = 1'b1;
                o_cmd.wd_sel   = (r_kind == K_INS) ? pss_pkg::WD_VALUE : pss_pkg::WD_TMP;
                o_cmd.fill_inc = (r_kind == K_INS);
                n_state        = S_FIN;
            end
            S_MOD: begin
                if (i_stat.mod_done) begin
                    if (i_stat.k_zero) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.idx_op = pss_pkg::IDX_FLIP_A;
                        n_phase      = PH_A;
                        n_state      = S_SW_RDI;
                    end
                end
            end
            S_SW_RDI: begin
                if (i_stat.i_lt_j) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SW_RDJ;
                end else begin
                    // rotation is three reversals: [0,k), [k,n), [0,n)
                    unique case (r_phase)
                        PH_A: begin
                            o_cmd.idx_op = pss_pkg::IDX_FLIP_B;
                            n_phase      = PH_B;
                        end
                        PH_B: begin
                            o_cmd.idx_op = pss_pkg::IDX_ZERO;
                            n_phase      = PH_C;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SW_RDJ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_j   = 1'b1;
                o_cmd.tmp_ld = 1'b1;
                n_state      = S_SW_WRI;
            end
            S_SW_WRI: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wd_sel = pss_pkg::WD_RDATA;
                n_state      = S_SW_WRJ;
            end
            S_SW_WRJ: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_j   = 1'b1;
                o_cmd.wd_sel = pss_pkg::WD_TMP;
                o_cmd.idx_op = pss_pkg::IDX_CLOSE;
                n_state      = S_SW_RDI;
            end
            S_DUMP_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_dump = 1'b1;
                    o_cmd.idx_op   = pss_pkg::IDX_UP;
                    n_state        = i_stat.i_last ? S_IDLE : S_DUMP_RD;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.st     = r_st;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_INS;
            r_phase <= PH_REV;
            r_st    <= pss_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_phase <= n_phase;
            r_st    <= n_st;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

@@ rtl/pss_dpath.sv @@
// Datapath: element memory, index registers, item registers, result register.
// Depends on pss_pkg and pss_mod.
module pss_dpath #(
    parameter int CAPACITY = pss_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pss_pkg::t_cmd                     i_cmd,
    output pss_pkg::t_stat                    o_stat,
    input  logic [pss_pkg::OP_W-1:0]          i_op,
    input  logic signed [pss_pkg::VAL_W-1:0]  i_value,
    input  logic [pss_pkg::POS_W-1:0]         i_position,
    input  logic [pss_pkg::POS_W-1:0]         i_target_position,
    input  logic [pss_pkg::AMT_W-1:0]         i_amount,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [pss_pkg::VAL_W-1:0]  o_element,
    output logic                              o_has_element,
    output logic [pss_pkg::ST_W-1:0]          o_status,
    output logic [pss_pkg::LEN_W-1:0]         o_length,
    output logic                              o_last
);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > pss_pkg::POS_W) ? CW : pss_pkg::POS_W;

    logic [pss_pkg::VAL_W-1:0] mem [CAPACITY];

    pss_pkg::t_op              r_op;
    logic [pss_pkg::VAL_W-1:0] r_value;
    logic [pss_pkg::POS_W-1:0] r_pos;
    logic [pss_pkg::POS_W-1:0] r_tgt;
    logic [pss_pkg::AMT_W-1:0] r_amt;
    logic [CW-1:0]             r_fill;
    logic [CW-1:0]             r_i, r_j, n_i, n_j;
    logic [pss_pkg::VAL_W-1:0] r_tmp;
    logic [pss_pkg::VAL_W-1:0] r_rdata;

    logic                      r_ovalid;
    logic [pss_pkg::VAL_W-1:0] r_oelem;
    logic                      r_ohas;
    pss_pkg::t_st              r_ost;
    logic [pss_pkg::LEN_W-1:0] r_olen;
    logic                      r_olast;

    logic [CMPW-1:0]           pos_x, tgt_x, n_x, i_x, j_x;
    logic [CW-1:0]             pos_c;
    logic [CW-1:0]             rem;
    logic                      mod_done;
    logic [CW-1:0]             kval;
    logic [CW-1:0]             rd_idx, wr_idx;
    logic [pss_pkg::VAL_W-1:0] wdata;
    logic                      out_free;

    pss_mod #(.CW(CW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (r_amt),
        .i_divisor  (r_fill),
        .o_done     (mod_done),
        .o_rem      (rem)
    );

    assign pos_x = CMPW'(r_pos);
    assign tgt_x = CMPW'(r_tgt);
    assign n_x   = CMPW'(r_fill);
    assign i_x   = CMPW'(r_i);
    assign j_x   = CMPW'(r_j);
    assign pos_c = pos_x[CW-1:0];

    // rotate right by r equals rotate left by n - r
    always_comb begin
        if (r_op == pss_pkg::OP_ROTL || rem == '0) begin
            kval = rem;
        end else begin
            kval = r_fill - rem;
        end
    end

    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        o_stat.op         = r_op;
        o_stat.full       = (r_fill == CW'(CAPACITY));
        o_stat.pos_gt_n   = (pos_x > n_x);
        o_stat.pos_ge_n   = (pos_x >= n_x);
        o_stat.tgt_ge_n   = (tgt_x >= n_x);
        o_stat.pos_eq_tgt = (pos_x == tgt_x);
        o_stat.tgt_gt_pos = (tgt_x > pos_x);
        o_stat.n_lt2      = (r_fill < CW'(2));
        o_stat.n_zero     = (r_fill == '0);
        o_stat.i_gt_pos   = (i_x > pos_x);
        o_stat.j_lt_n     = (j_x < n_x);
        o_stat.i_lt_tgt   = (i_x < tgt_x);
        o_stat.i_gt_tgt   = (i_x > tgt_x);
        o_stat.i_lt_j     = (r_i < r_j);
        o_stat.i_last     = (r_i == r_fill - 1'b1);
        o_stat.k_zero     = (kval == '0);
        o_stat.mod_done   = mod_done;
        o_stat.out_free   = out_free;
    end

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        unique case (i_cmd.idx_op)
            pss_pkg::IDX_HOLD: ;
            pss_pkg::IDX_UP: begin
                n_i = r_i + 1'b1;
                n_j = r_j + 1'b1;
            end
            pss_pkg::IDX_DN: begin
                n_i = r_i - 1'b1;
                n_j = r_j - 1'b1;
            end
            pss_pkg::IDX_CLOSE: begin
                n_i = r_i + 1'b1;
                n_j = r_j - 1'b1;
            end
            pss_pkg::IDX_INS: begin
                n_i = r_fill;
                n_j = r_fill - 1'b1;
            end
            pss_pkg::IDX_FWD: begin
                n_i = pos_c;
                n_j = pos_c + 1'b1;
            end
            pss_pkg::IDX_BWD: begin
                n_i = pos_c;
                n_j = pos_c - 1'b1;
            end
            pss_pkg::IDX_FLIP_A: begin
                n_i = '0;
                n_j = kval - 1'b1;
            end
            pss_pkg::IDX_FLIP_B: begin
                n_i = kval;
                n_j = r_fill - 1'b1;
            end
            pss_pkg::IDX_ZERO: begin
                n_i = '0;
                n_j = r_fill - 1'b1;
            end
            default: ;
        endcase
    end

    assign rd_idx = i_cmd.rd_j ? r_j : r_i;
    assign wr_idx = i_cmd.wr_j ? r_j : r_i;

    always_comb begin
        unique case (i_cmd.wd_sel)
            pss_pkg::WD_VALUE: wdata = r_value;
            pss_pkg::WD_TMP:   wdata = r_tmp;
            default:           wdata = r_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_idx[AW-1:0]] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        if (i_cmd.tmp_ld) begin
            r_tmp <= r_rdata;
        end
        if (i_cmd.load_item) begin
            r_value <= i_value;
            r_pos   <= i_position;
            r_tgt   <= i_target_position;
            r_amt   <= i_amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= pss_pkg::OP_INSERT;
            r_fill <= '0;
        end else begin
            if (i_cmd.load_item) begin
                r_op <= i_op;
            end
            if (i_cmd.fill_inc) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_cmd.fill_dec) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_olen <= n_x[pss_pkg::LEN_W-1:0];
            if (i_cmd.out_dump) begin
                r_oelem <= r_rdata;
                r_ohas  <= 1'b1;
                r_ost   <= pss_pkg::ST_OK;
                r_olast <= o_stat.i_last;
            end else begin
                r_oelem <= '0;
                r_ohas  <= 1'b0;
                r_ost   <= i_cmd.st;
                r_olast <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_element     = r_oelem;
    assign o_has_element = r_ohas;
    assign o_status      = r_ost;
    assign o_length      = r_olen;
    assign o_last        = r_olast;
endmodule

@@ rtl/positional_sequence_store_unit.sv @@
// Positional sequence store: an ordered list of signed 32-bit values edited by
// position (insert, remove, move, reverse, rotate) and read out by dump.
// Items arrive on i_in (valid/ready) and results leave on o_out (valid/ready).
// One item is worked at a time; i_in.ready is high only while idle. Every
// operation but dump yields one status result; a dump yields one result per
// element with the final one marked by last, or one marker result if empty.
// Every editing operation and dump steps through the element memory, reading
// or writing one element at a time. Rotate first takes the amount modulo
// the length in the bit-serial remainder unit, then does three reversals.
// The result register frees the controller as soon as it is loaded, so the
// next item is taken while a result still waits. A stall on o_out holds the
// controller only when it has a new result to load.
// Reset empties the store at once (length zero); stored cells are not cleared
// and are never read before they are written.
// Depends on pss_pkg, pss_if, pss_ctrl, pss_dpath and the macros header.
`include "positional_sequence_store_unit_macros.svh"

module positional_sequence_store_unit #(
    parameter int CAPACITY = pss_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pss_in_if.sink     i_in,
    pss_out_if.source  o_out
);
    pss_pkg::t_cmd  cmd;
    pss_pkg::t_stat stat;

    pss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pss_dpath #(.CAPACITY(CAPACITY)) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_op              (i_in.op),
        .i_value           (i_in.value),
        .i_position        (i_in.position),
        .i_target_position (i_in.target_position),
        .i_amount          (i_in.amount),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_element         (o_out.element),
        .o_has_element     (o_out.has_element),
        .o_status          (o_out.status),
        .o_length          (o_out.length),
        .o_last            (o_out.last)
    );

    `PSS_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready, "ready")
    `PSS_ASSERT_NOW(a_dump_ok, o_out.valid && o_out.has_element, o_out.status == 2'd0, "dump st")
    `PSS_ASSERT_NOW(a_status_last, o_out.valid && !o_out.has_element, o_out.last, "not last")
    `PSS_ASSERT_NOW(a_status_zero, o_out.valid && !o_out.has_element, o_out.element == '0, "elem")
    `PSS_ASSERT_NOW(a_length_bound, o_out.valid, 32'(o_out.length) <= 32'(CAPACITY), "length")
endmodule
